// ===== rtl/keyframe_track_interpolator_defines.svh =====
// ---------------------------------------------------------------------------
// Keyframe track interpolator assertion macros
// Shared property forms for the port checker.
// ---------------------------------------------------------------------------
`ifndef KEYFRAME_TRACK_INTERPOLATOR_DEFINES_SVH
`define KEYFRAME_TRACK_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication, off during reset
`define KTIP_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset
`define KTIP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Condition that must hold in the cycle after reset is seen
`define KTIP_ASSERT_RESET(label, cons, msg) \
    label: assert property (@(posedge aclk) (!aresetn) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ktip_pkg.sv =====
// ---------------------------------------------------------------------------
// ktip_pkg
// Types, widths and codes shared by the keyframe track interpolator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ktip_pkg;

    localparam int MAX_KEYS  = 32;
    localparam int LANES     = 4;
    localparam int NUM_COMP  = 4;
    localparam int ROW_W     = 24;
    localparam int VAL_W     = 32;
    localparam int MODE_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int FRAC_W    = 16;
    localparam int T_W       = FRAC_W + 1;
    localparam int IDX_W     = $clog2(MAX_KEYS);
    localparam int CNT_W     = $clog2(MAX_KEYS + 1);
    localparam int DIV_CNT_W = $clog2(FRAC_W + 1);

    localparam int S_TDATA_W = 160;
    localparam int M_TDATA_W = NUM_COMP * VAL_W;

    // 3.0 in Q2.16, for the smoothstep factor
    localparam logic [T_W:0] SMOOTH_K = (T_W + 1)'(3 << FRAC_W);

    // Interpolation modes (the unused code behaves as linear)
    localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STEP   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SMOOTH = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_EVAL     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INSERTED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_UPDATED  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd3;

    // Item kinds on tuser
    localparam logic FUNC_EVAL = 1'b0;
    localparam logic FUNC_ADD  = 1'b1;

    typedef struct packed {
        logic [MODE_W-1:0]                mode;
        logic [NUM_COMP-1:0][VAL_W-1:0]   vals;
        logic [ROW_W-1:0]                 row;
    } key_entry_t;

    localparam int KEY_W = $bits(key_entry_t);

    typedef struct packed {
        logic           done;
        logic [T_W-1:0] q;
    } div_res_t;

endpackage

// ===== rtl/ktip_ram.sv =====
// ---------------------------------------------------------------------------
// ktip_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ktip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/ktip_div.sv =====
// ---------------------------------------------------------------------------
// ktip_div
// Radix-2 divider forming the segment fraction t = (num << 16) / den.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ktip_div import ktip_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [ROW_W-1:0] num,
    input  logic [ROW_W-1:0] den,
    output div_res_t         res
);

    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [ROW_W-1:0]     rem_reg;
    logic [ROW_W-1:0]     den_reg;
    logic [T_W-1:0]       q_reg;
    logic                 zero_reg;
    logic [ROW_W:0]       rem2;
    logic                 ge;

    // One quotient bit per cycle; num never exceeds den
    assign rem2 = {rem_reg, 1'b0};
    assign ge   = (rem2 >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_W'(FRAC_W);
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Quotient and remainder datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            den_reg  <= den;
            zero_reg <= (den == '0);
            if (num >= den) begin
                rem_reg <= num - den;
                q_reg   <= T_W'(1);
            end else begin
                rem_reg <= num;
                q_reg   <= '0;
            end
        end else if (busy_reg && (cnt_reg != '0)) begin
            rem_reg <= ge ? ROW_W'(rem2 - {1'b0, den_reg}) : rem2[ROW_W-1:0];
            q_reg   <= {q_reg[T_W-2:0], ge};
        end
    end

    // A zero span gives t of zero
    assign res.done = busy_reg && (cnt_reg == '0);
    assign res.q    = zero_reg ? '0 : q_reg;

endmodule

// ===== rtl/ktip_lane.sv =====
// ---------------------------------------------------------------------------
// ktip_lane
// One component lane: a + floor((b - a) * t / 65536), two register stages.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ktip_lane import ktip_pkg::*; (
    input  logic                    aclk,
    input  logic signed [VAL_W-1:0] a_val,
    input  logic signed [VAL_W-1:0] b_val,
    input  logic [T_W-1:0]          t,
    output logic signed [VAL_W-1:0] res
);

    logic signed [VAL_W:0]         diff;
    logic signed [VAL_W+T_W+1:0]   prod_reg;
    logic signed [VAL_W-1:0]       a_reg;
    logic signed [VAL_W+T_W+1:0]   scaled;

    // Sign-extend both ends so the difference keeps its sign
    assign diff = {b_val[VAL_W-1], b_val} - {a_val[VAL_W-1], a_val};

    // Stage one: scale the difference
    always_ff @(posedge aclk) begin
        prod_reg <= diff * $signed({1'b0, t});
        a_reg    <= a_val;
    end

    // Stage two: floor shift and add back the base; result stays between a and b
    assign scaled = prod_reg >>> FRAC_W;

    always_ff @(posedge aclk) begin
        res <= VAL_W'(a_reg + scaled);
    end

endmodule

// ===== rtl/keyframe_track_interpolator.sv =====
// ---------------------------------------------------------------------------
// keyframe_track_interpolator
// Sorted keyframe table with insert/update and step, linear and smoothstep
// evaluation over four value lanes.
// ---------------------------------------------------------------------------
//  channel | direction | tuser          | tdata (low bit up)
//  s_      | in        | func           | row, value_x, value_y, value_z, value_w, mode
//  m_      | out       | status         | out_x, out_y, out_z, out_w
//
//  Per request: a RAM read (S_RD) and a compare (S_CHK) per entry walked,
//  then the fraction divider, the smoothstep steps (S_SM1, S_SM2) and the
//  lane stages (S_LN1, S_LN2). An insert shifts each later entry up with a
//  read (S_SHR) and write (S_SHW); RAM: one entry read or written per cycle.
//  Reset clears the key count and the handshakes; the table needs no pass.
//  A stalled result waits in the output register; the next request is taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module keyframe_track_interpolator import ktip_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // row, value_x, value_y, value_z, value_w, mode
    input  logic                  s_tuser,   // func
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // out_x, out_y, out_z, out_w
    output logic [STATUS_W-1:0]   m_tuser    // status
);

    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_RD   = 12'b0000_0000_0010,
        S_CHK  = 12'b0000_0000_0100,
        S_DIV  = 12'b0000_0000_1000,
        S_SM1  = 12'b0000_0001_0000,
        S_SM2  = 12'b0000_0010_0000,
        S_LN1  = 12'b0000_0100_0000,
        S_LN2  = 12'b0000_1000_0000,
        S_SHR  = 12'b0001_0000_0000,
        S_SHW  = 12'b0010_0000_0000,
        S_INS  = 12'b0100_0000_0000,
        S_DONE = 12'b1000_0000_0000
    } state_t;

    state_t                 state_reg, state_next;
    logic                   func_reg;
    key_entry_t             new_reg;
    logic [CNT_W-1:0]       k_reg;
    logic [CNT_W-1:0]       pos_reg;
    logic [CNT_W-1:0]       count_reg;
    key_entry_t             prev_reg;
    key_entry_t             a_sel_reg;
    key_entry_t             b_sel_reg;
    logic [T_W-1:0]         t_reg;
    logic [T_W-1:0]         u_reg;
    logic [STATUS_W-1:0]    status_reg;
    logic                   zero_reg;
    logic                   m_tvalid_reg;
    logic [M_TDATA_W-1:0]   m_tdata_reg;
    logic [STATUS_W-1:0]    m_tuser_reg;

    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    key_entry_t             ram_wdata;
    logic [IDX_W-1:0]       ram_raddr;
    key_entry_t             cur;

    logic                   accept;
    logic                   at_end;
    logic                   is_last;
    logic                   row_le;
    logic                   row_ge;
    logic                   row_eq;
    logic                   is_full;
    logic                   out_free;
    logic                   div_start;
    logic [ROW_W-1:0]       div_num;
    logic [ROW_W-1:0]       div_den;
    div_res_t               div_res;
    logic [2*T_W-1:0]       tsq;
    logic [T_W:0]           sfac;
    logic [2*T_W:0]         sprod;
    logic [NUM_COMP-1:0][VAL_W-1:0] lane_res;

    // Key table: one entry per word
    ktip_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_KEYS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (cur)
    );

    ktip_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .res     (div_res)
    );

    // Lanes past LANES are not stored and read as zero
    for (genvar g = 0; g < NUM_COMP; g++) begin : g_lane
        if (g < LANES) begin : g_on
            ktip_lane u_lane (
                .aclk  (aclk),
                .a_val (a_sel_reg.vals[g]),
                .b_val (b_sel_reg.vals[g]),
                .t     (t_reg),
                .res   (lane_res[g])
            );
        end else begin : g_off
            assign lane_res[g] = '0;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Compare the request row against the entry just read
    assign at_end  = (k_reg == count_reg);
    assign is_last = (k_reg == count_reg - 1'b1);
    assign is_full = (count_reg == CNT_W'(MAX_KEYS));
    assign row_le  = ($signed(new_reg.row) <= $signed(cur.row));
    assign row_ge  = ($signed(new_reg.row) >= $signed(cur.row));
    assign row_eq  = (new_reg.row == cur.row);

    // Fraction operands for the segment prev..cur
    assign div_num   = ROW_W'(new_reg.row - prev_reg.row);
    assign div_den   = ROW_W'(cur.row - prev_reg.row);
    assign div_start = (state_reg == S_CHK) && (func_reg == FUNC_EVAL) && (k_reg != '0)
                       && !(is_last && row_ge) && row_le && (prev_reg.mode != MODE_STEP);

    // Smoothstep products
    assign tsq   = t_reg * t_reg;
    assign sfac  = SMOOTH_K - {t_reg, 1'b0};
    assign sprod = u_reg * sfac;

    // RAM port steering
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = k_reg[IDX_W-1:0];
        ram_wdata = new_reg;
        ram_raddr = k_reg[IDX_W-1:0];
        case (state_reg)
            S_CHK: begin
                ram_we = (func_reg == FUNC_ADD) && row_eq;
            end
            S_SHR: begin
                ram_raddr = IDX_W'(k_reg - 1'b1);
            end
            S_SHW: begin
                ram_we    = 1'b1;
                ram_wdata = cur;
            end
            S_INS: begin
                ram_we    = 1'b1;
                ram_waddr = pos_reg[IDX_W-1:0];
            end
            default: begin
            end
        endcase
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (accept) state_next = S_RD;
            S_RD: begin
                if (!at_end) begin
                    state_next = S_CHK;
                end else if (func_reg == FUNC_EVAL || is_full) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_SHR;
                end
            end
            S_CHK: begin
                if (func_reg == FUNC_ADD) begin
                    if (row_eq || (!row_le && !row_ge)) begin
                        state_next = row_eq ? S_DONE : S_RD;
                    end else if (row_le) begin
                        state_next = is_full ? S_DONE : S_SHR;
                    end else begin
                        state_next = S_RD;
                    end
                end else if (k_reg == '0) begin
                    state_next = (row_le || count_reg == CNT_W'(1)) ? S_LN1 : S_RD;
                end else if (is_last && row_ge) begin
                    state_next = S_LN1;
                end else if (row_le) begin
                    state_next = (prev_reg.mode == MODE_STEP) ? S_LN1 : S_DIV;
                end else begin
                    state_next = S_RD;
                end
            end
            S_DIV: begin
                if (div_res.done) begin
                    state_next = (a_sel_reg.mode == MODE_SMOOTH) ? S_SM1 : S_LN1;
                end
            end
            S_SM1:  state_next = S_SM2;
            S_SM2:  state_next = S_LN1;
            S_LN1:  state_next = S_LN2;
            S_LN2:  state_next = S_DONE;
            S_SHR:  state_next = (k_reg == pos_reg) ? S_INS : S_SHW;
            S_SHW:  state_next = S_SHR;
            S_INS:  state_next = S_DONE;
            S_DONE: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_INS) begin
                count_reg <= count_reg + 1'b1;
            end
            if (state_reg == S_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Request and walk datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    func_reg        <= s_tuser;
                    new_reg.row     <= s_tdata[ROW_W-1:0];
                    for (int j = 0; j < NUM_COMP; j++) begin
                        new_reg.vals[j] <= (j < LANES) ? s_tdata[ROW_W+j*VAL_W +: VAL_W] : '0;
                    end
                    new_reg.mode    <= s_tdata[ROW_W+NUM_COMP*VAL_W +: MODE_W];
                    k_reg           <= '0;
                    zero_reg        <= 1'b1;
                    status_reg      <= STATUS_EVAL;
                end
            end
            S_RD: begin
                // End of table on add: append after the last key
                if (at_end && func_reg == FUNC_ADD) begin
                    pos_reg    <= k_reg;
                    status_reg <= is_full ? STATUS_FULL : STATUS_INSERTED;
                end
            end
            S_CHK: begin
                prev_reg <= cur;
                if (func_reg == FUNC_ADD) begin
                    if (row_eq) begin
                        status_reg <= STATUS_UPDATED;
                    end else if (row_le) begin
                        pos_reg    <= k_reg;
                        k_reg      <= count_reg;
                        status_reg <= is_full ? STATUS_FULL : STATUS_INSERTED;
                    end else begin
                        k_reg <= k_reg + 1'b1;
                    end
                end else if ((k_reg == '0 && (row_le || count_reg == CNT_W'(1)))
                             || (k_reg != '0 && is_last && row_ge)) begin
                    // Clamp to this key
                    a_sel_reg <= cur;
                    b_sel_reg <= cur;
                    t_reg     <= '0;
                    zero_reg  <= 1'b0;
                end else if (k_reg != '0 && row_le) begin
                    // Segment found; a step segment holds the earlier key
                    a_sel_reg <= prev_reg;
                    b_sel_reg <= cur;
                    t_reg     <= '0;
                    zero_reg  <= 1'b0;
                end else begin
                    k_reg <= k_reg + 1'b1;
                end
            end
            S_DIV: begin
                if (div_res.done) begin
                    t_reg <= div_res.q;
                end
            end
            S_SM1: begin
                u_reg <= tsq[FRAC_W +: T_W];
            end
            S_SM2: begin
                t_reg <= sprod[FRAC_W +: T_W];
            end
            S_SHW: begin
                k_reg <= k_reg - 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Merge lane results into the output register
    always_ff @(posedge aclk) begin
        if (state_reg == S_DONE && out_free) begin
            m_tdata_reg <= zero_reg ? '0 : lane_res;
            m_tuser_reg <= status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== rtl/ktip_checker.sv =====
// ---------------------------------------------------------------------------
// ktip_checker
// Port-level checks for the keyframe track interpolator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "keyframe_track_interpolator_defines.svh"

module ktip_checker import ktip_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [STATUS_W-1:0]  m_tuser
);

    // Stalled result keeps its contents
    `KTIP_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // Add results carry zero components
    `KTIP_ASSERT_IMPLY(a_add_zero, m_tvalid && (m_tuser != STATUS_EVAL), m_tdata == '0, "add result not zero")

    // One request at a time: busy right after an accept
    `KTIP_ASSERT_NEXT(a_busy, s_tvalid && s_tready, !s_tready, "request taken while busy")

    // No result right after reset
    `KTIP_ASSERT_RESET(a_rst, !m_tvalid, "result valid after reset")

endmodule

bind keyframe_track_interpolator ktip_checker u_ktip_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
